>>> src/skvd_pkg.sv
// shared types and constants for the sorted key/value deque
package skvd_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CmdW = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW = 5;

  localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CmdW-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CmdW-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CmdW-1:0] CMD_INSERT     = 3'd4;
  localparam logic [CmdW-1:0] CMD_CLEAR      = 3'd5;

  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  // per-transaction control broadcast to every cell
  typedef struct packed {
    logic insert;      // an entry goes in at the first cell that hits
    logic front;       // every cell hits (push front)
    logic sorted;      // a valid cell hits when its key is >= the new key
    logic shift_left;  // every cell takes its right neighbor (pop front)
  } cell_ctl_t;

endpackage

>>> src/skvd_cell.sv
// one storage cell of the deque row: holds one key/value pair
module skvd_cell (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  skvd_pkg::cell_ctl_t                ctl_i,
  input  logic                               valid_i,
  input  logic                               found_i,
  input  logic signed [skvd_pkg::KeyW-1:0]   new_key_i,
  input  logic signed [skvd_pkg::ValW-1:0]   new_value_i,
  input  logic signed [skvd_pkg::KeyW-1:0]   left_key_i,
  input  logic signed [skvd_pkg::ValW-1:0]   left_value_i,
  input  logic signed [skvd_pkg::KeyW-1:0]   right_key_i,
  input  logic signed [skvd_pkg::ValW-1:0]   right_value_i,
  output logic signed [skvd_pkg::KeyW-1:0]   key_o,
  output logic signed [skvd_pkg::ValW-1:0]   value_o,
  output logic                               found_o
);

  logic signed [skvd_pkg::KeyW-1:0] key_q, key_d;
  logic signed [skvd_pkg::ValW-1:0] value_q, value_d;
  logic                             hit;

  // empty cells always hit, so push back lands at the first empty cell
  assign hit = !valid_i || ctl_i.front || (ctl_i.sorted && !(key_q < new_key_i));
  assign found_o = found_i || hit;

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ctl_i.shift_left) begin
      key_d   = right_key_i;
      value_d = right_value_i;
    end else if (ctl_i.insert) begin
      if (found_i) begin
        key_d   = left_key_i;
        value_d = left_value_i;
      end else if (hit) begin
        key_d   = new_key_i;
        value_d = new_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q   <= key_d;
      value_q <= value_d;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

>>> src/sorted_key_value_deque.sv
// sorted key/value deque: a row of cells with a shared count and result register
// latency: result is valid the cycle after the command transaction is accepted
// throughput: one command per cycle; input is ready whenever the result register is free
//   or being taken; a sorted insert settles combinationally through the row's hit chain
// reset: clears the entry count, status and result valid; cell contents are not cleared
module sorted_key_value_deque #(
  parameter int unsigned DEPTH = skvd_pkg::DefaultDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [skvd_pkg::CmdW-1:0]            cmd_i,
  input  logic signed [skvd_pkg::KeyW-1:0]     entry_key_i,
  input  logic signed [skvd_pkg::ValW-1:0]     entry_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [skvd_pkg::StatusW-1:0]         status_o,
  output logic [skvd_pkg::OccW-1:0]            occupancy_o,
  output logic signed [skvd_pkg::KeyW-1:0]     head_key_o,
  output logic signed [skvd_pkg::ValW-1:0]     head_value_o,
  output logic signed [skvd_pkg::KeyW-1:0]     tail_key_o,
  output logic signed [skvd_pkg::ValW-1:0]     tail_value_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  logic [CntW-1:0]                  count_q, count_d;
  logic [skvd_pkg::StatusW-1:0]     status_q, status_d;
  logic                             out_valid_q;
  logic                             accept;
  logic                             full, empty, is_add;
  skvd_pkg::cell_ctl_t              ctl;
  logic [DEPTH:0]                   found;
  logic [DEPTH-1:0]                 valid;
  logic signed [skvd_pkg::KeyW-1:0] cell_key [DEPTH];
  logic signed [skvd_pkg::ValW-1:0] cell_value [DEPTH];
  logic [IdxW-1:0]                  tail_idx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);
  assign is_add     = (cmd_i == skvd_pkg::CMD_PUSH_BACK) || (cmd_i == skvd_pkg::CMD_PUSH_FRONT)
                   || (cmd_i == skvd_pkg::CMD_INSERT);

  always_comb begin
    ctl      = '0;
    count_d  = count_q;
    status_d = skvd_pkg::ST_DONE;
    unique case (cmd_i)
      skvd_pkg::CMD_PUSH_BACK, skvd_pkg::CMD_PUSH_FRONT, skvd_pkg::CMD_INSERT: begin
        if (full) begin
          status_d = skvd_pkg::ST_FULL;
        end else begin
          ctl.insert = 1'b1;
          ctl.front  = (cmd_i == skvd_pkg::CMD_PUSH_FRONT);
          ctl.sorted = (cmd_i == skvd_pkg::CMD_INSERT);
          count_d    = count_q + CntW'(1);
        end
      end
      skvd_pkg::CMD_POP_BACK: begin
        if (empty) status_d = skvd_pkg::ST_EMPTY;
        else count_d = count_q - CntW'(1);
      end
      skvd_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status_d = skvd_pkg::ST_EMPTY;
        end else begin
          ctl.shift_left = 1'b1;
          count_d        = count_q - CntW'(1);
        end
      end
      skvd_pkg::CMD_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [skvd_pkg::KeyW-1:0] left_key, right_key;
    logic signed [skvd_pkg::ValW-1:0] left_value, right_value;

    assign valid[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_key   = entry_key_i;
      assign left_value = entry_value_i;
    end else begin : g_mid_l
      assign left_key   = cell_key[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key   = cell_key[i];
      assign right_value = cell_value[i];
    end else begin : g_mid_r
      assign right_key   = cell_key[i+1];
      assign right_value = cell_value[i+1];
    end

    skvd_cell u_cell (
      .clk_i        (clk_i),
      .en_i         (accept),
      .ctl_i        (ctl),
      .valid_i      (valid[i]),
      .found_i      (found[i]),
      .new_key_i    (entry_key_i),
      .new_value_i  (entry_value_i),
      .left_key_i   (left_key),
      .left_value_i (left_value),
      .right_key_i  (right_key),
      .right_value_i(right_value),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .found_o      (found[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      status_q    <= skvd_pkg::ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q  <= count_d;
        status_q <= status_d;
      end
      if (in_ready_o) out_valid_q <= in_valid_i;
    end
  end

  // state only moves on a transaction that also frees the result, so results read the cells
  assign tail_idx     = IdxW'(count_q - CntW'(1));
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign occupancy_o  = skvd_pkg::OccW'(count_q);
  assign head_key_o   = empty ? '0 : cell_key[0];
  assign head_value_o = empty ? '0 : cell_value[0];
  assign tail_key_o   = empty ? '0 : cell_key[tail_idx];
  assign tail_value_o = empty ? '0 : cell_value[tail_idx];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_add && full) |=> (count_q == $past(count_q)) && (status_q == skvd_pkg::ST_FULL))
    else $error("add to full store changed the count");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == skvd_pkg::ST_EMPTY) |-> empty)
    else $error("empty status with entries held");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == skvd_pkg::ST_FULL) |-> full)
    else $error("full status with room left");

endmodule

>>> sim/skvd_checker.sv
// checker for the sorted key/value deque: tracks the store and compares every result
`timescale 1ns / 1ps

module skvd_checker #(
  parameter int unsigned DEPTH = skvd_pkg::DefaultDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [skvd_pkg::CmdW-1:0]           cmd_i,
  input  logic signed [skvd_pkg::KeyW-1:0]    entry_key_i,
  input  logic signed [skvd_pkg::ValW-1:0]    entry_value_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [skvd_pkg::StatusW-1:0]        status_i,
  input  logic [skvd_pkg::OccW-1:0]           occupancy_i,
  input  logic signed [skvd_pkg::KeyW-1:0]    head_key_i,
  input  logic signed [skvd_pkg::ValW-1:0]    head_value_i,
  input  logic signed [skvd_pkg::KeyW-1:0]    tail_key_i,
  input  logic signed [skvd_pkg::ValW-1:0]    tail_value_i,
  output int                                  mismatch_count_o,
  output int                                  outstanding_o,
  output int                                  commands_o,
  output int                                  full_drops_o,
  output int                                  empty_pops_o
);

  typedef struct packed {
    logic [skvd_pkg::StatusW-1:0]     status;
    logic [skvd_pkg::OccW-1:0]        occupancy;
    logic signed [skvd_pkg::KeyW-1:0] head_key;
    logic signed [skvd_pkg::ValW-1:0] head_value;
    logic signed [skvd_pkg::KeyW-1:0] tail_key;
    logic signed [skvd_pkg::ValW-1:0] tail_value;
  } deque_view_t;

  logic signed [skvd_pkg::KeyW-1:0] key_store   [DEPTH];
  logic signed [skvd_pkg::ValW-1:0] value_store [DEPTH];
  int unsigned                      entry_count = 0;

  deque_view_t pending_views[$];
  int          mismatches  = 0;
  int          commands    = 0;
  int          full_drops  = 0;
  int          empty_pops  = 0;

  // updates the tracked store for one command and returns what the block should report
  task automatic apply_command(input logic [skvd_pkg::CmdW-1:0] op,
                               input logic signed [skvd_pkg::KeyW-1:0] k,
                               input logic signed [skvd_pkg::ValW-1:0] v,
                               output deque_view_t view);
    int unsigned pos;
    int unsigned i;
    view.status = skvd_pkg::ST_DONE;
    case (op)
      skvd_pkg::CMD_PUSH_BACK, skvd_pkg::CMD_PUSH_FRONT, skvd_pkg::CMD_INSERT: begin
        if (entry_count >= DEPTH) begin
          view.status = skvd_pkg::ST_FULL;
        end else begin
          if (op == skvd_pkg::CMD_PUSH_BACK) begin
            pos = entry_count;
          end else if (op == skvd_pkg::CMD_PUSH_FRONT) begin
            pos = 0;
          end else begin
            // equal keys: new entry lands ahead of them
            pos = 0;
            while (pos < entry_count && key_store[pos] < k) pos++;
          end
          for (i = entry_count; i > pos; i--) begin
            key_store[i]   = key_store[i-1];
            value_store[i] = value_store[i-1];
          end
          key_store[pos]   = k;
          value_store[pos] = v;
          entry_count++;
        end
      end
      skvd_pkg::CMD_POP_BACK: begin
        if (entry_count == 0) view.status = skvd_pkg::ST_EMPTY;
        else entry_count--;
      end
      skvd_pkg::CMD_POP_FRONT: begin
        if (entry_count == 0) begin
          view.status = skvd_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < entry_count; i++) begin
            key_store[i]   = key_store[i+1];
            value_store[i] = value_store[i+1];
          end
          entry_count--;
        end
      end
      skvd_pkg::CMD_CLEAR: entry_count = 0;
      default: ;
    endcase
    view.occupancy = skvd_pkg::OccW'(entry_count);
    if (entry_count == 0) begin
      view.head_key   = '0;
      view.head_value = '0;
      view.tail_key   = '0;
      view.tail_value = '0;
    end else begin
      view.head_key   = key_store[0];
      view.head_value = value_store[0];
      view.tail_key   = key_store[entry_count-1];
      view.tail_value = value_store[entry_count-1];
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    deque_view_t view;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pending_views.size() == 0) begin
          $error("result transaction with no command waiting for it");
          mismatches++;
        end else begin
          view = pending_views[0];
          pending_views.delete(0);
          check_field("status", 32'(view.status), 32'(status_i));
          check_field("occupancy", 32'(view.occupancy), 32'(occupancy_i));
          check_field("head_key", view.head_key, head_key_i);
          check_field("head_value", view.head_value, head_value_i);
          check_field("tail_key", view.tail_key, tail_key_i);
          check_field("tail_value", view.tail_value, tail_value_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_command(cmd_i, entry_key_i, entry_value_i, view);
        pending_views.insert(pending_views.size(), view);
        commands++;
        if (view.status == skvd_pkg::ST_FULL) full_drops++;
        if (view.status == skvd_pkg::ST_EMPTY) empty_pops++;
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= pending_views.size();
    commands_o       <= commands;
    full_drops_o     <= full_drops;
    empty_pops_o     <= empty_pops;
  end

endmodule

>>> sim/tb_sorted_key_value_deque.sv
// testbench top for the sorted key/value deque: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_sorted_key_value_deque;

  localparam int unsigned DEPTH = skvd_pkg::DefaultDepth;
  localparam logic [skvd_pkg::CmdW-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [skvd_pkg::CmdW-1:0] CMD_SPARE_HI = 3'd7;
  localparam int unsigned PHASE_ITEMS = 375;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIXED} burst_mode_e;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic [skvd_pkg::CmdW-1:0]        cmd_i = skvd_pkg::CMD_PUSH_BACK;
  logic signed [skvd_pkg::KeyW-1:0] entry_key_i = '0;
  logic signed [skvd_pkg::ValW-1:0] entry_value_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic [skvd_pkg::StatusW-1:0]     status_o;
  logic [skvd_pkg::OccW-1:0]        occupancy_o;
  logic signed [skvd_pkg::KeyW-1:0] head_key_o;
  logic signed [skvd_pkg::ValW-1:0] head_value_o;
  logic signed [skvd_pkg::KeyW-1:0] tail_key_o;
  logic signed [skvd_pkg::ValW-1:0] tail_value_o;

  int mismatch_count;
  int outstanding;
  int commands;
  int full_drops;
  int empty_pops;

  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 79;

  always #5 clk_i = ~clk_i;

  sorted_key_value_deque #(.DEPTH(DEPTH)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .entry_key_i, .entry_value_i,
    .out_valid_o, .out_ready_i, .status_o, .occupancy_o, .head_key_o, .head_value_o,
    .tail_key_o, .tail_value_o
  );

  skvd_checker #(.DEPTH(DEPTH)) i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .entry_key_i,
    .entry_value_i, .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .occupancy_i(occupancy_o), .head_key_i(head_key_o), .head_value_i(head_value_o),
    .tail_key_i(tail_key_o), .tail_value_i(tail_value_o),
    .mismatch_count_o(mismatch_count), .outstanding_o(outstanding), .commands_o(commands),
    .full_drops_o(full_drops), .empty_pops_o(empty_pops)
  );

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("sorted_key_value_deque verification failed");
    $finish;
  end

  task automatic send_command(input logic [skvd_pkg::CmdW-1:0] op,
                              input logic signed [skvd_pkg::KeyW-1:0] k,
                              input logic signed [skvd_pkg::ValW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= op;
    entry_key_i   <= k;
    entry_value_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold off new commands until every outstanding result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // small keys collide often, which exercises the equal-key ordering
  function automatic logic signed [31:0] random_word();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($urandom_range(8)) - 32'sd4;
      4: begin
        case ($urandom_range(3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [skvd_pkg::CmdW-1:0] pick_command(burst_mode_e mode);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (roll < 40) return skvd_pkg::CMD_INSERT;
        else if (roll < 62) return skvd_pkg::CMD_PUSH_BACK;
        else if (roll < 84) return skvd_pkg::CMD_PUSH_FRONT;
        else if (roll < 92) return skvd_pkg::CMD_POP_FRONT;
        else return skvd_pkg::CMD_POP_BACK;
      end
      MODE_DRAIN: begin
        if (roll < 40) return skvd_pkg::CMD_POP_BACK;
        else if (roll < 80) return skvd_pkg::CMD_POP_FRONT;
        else if (roll < 92) return skvd_pkg::CMD_INSERT;
        else return skvd_pkg::CMD_PUSH_BACK;
      end
      default: begin
        if (roll < 2) return skvd_pkg::CMD_CLEAR;
        else if (roll < 4) return CMD_SPARE_LO;
        else if (roll < 6) return CMD_SPARE_HI;
        else if (roll < 25) return skvd_pkg::CMD_PUSH_BACK;
        else if (roll < 43) return skvd_pkg::CMD_PUSH_FRONT;
        else if (roll < 62) return skvd_pkg::CMD_POP_BACK;
        else if (roll < 80) return skvd_pkg::CMD_POP_FRONT;
        else return skvd_pkg::CMD_INSERT;
      end
    endcase
  endfunction

  initial begin
    burst_mode_e mode;
    int unsigned burst_left;
    int unsigned phase;
    int unsigned n;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, ignored fields, ordering of inserts, extremes
    send_command(skvd_pkg::CMD_POP_BACK, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_command(skvd_pkg::CMD_POP_FRONT, 32'sh80000000, 32'sh80000000);
    send_command(CMD_SPARE_LO, 32'sh7FFFFFFF, -32'sd1);
    send_command(skvd_pkg::CMD_CLEAR, 32'sh12345678, 32'sh0);
    send_command(skvd_pkg::CMD_INSERT, 32'sd7, 32'sd70);
    send_command(skvd_pkg::CMD_POP_FRONT, 32'sd0, 32'sd0);
    send_command(skvd_pkg::CMD_PUSH_BACK, 32'sh7FFFFFFF, 32'sh80000000);
    send_command(skvd_pkg::CMD_PUSH_FRONT, 32'sh80000000, 32'sh7FFFFFFF);
    send_command(skvd_pkg::CMD_INSERT, 32'sd0, 32'sd1);
    send_command(skvd_pkg::CMD_INSERT, 32'sd0, 32'sd2);
    send_command(skvd_pkg::CMD_INSERT, -32'sd1, -32'sd1);
    send_command(skvd_pkg::CMD_INSERT, 32'sh7FFFFFFF, 32'sd5);
    send_command(skvd_pkg::CMD_INSERT, 32'sh80000000, 32'sd6);
    send_command(CMD_SPARE_HI, 32'shAAAAAAAA, 32'sh55555555);
    send_command(skvd_pkg::CMD_POP_BACK, 32'sd0, 32'sd0);
    send_command(skvd_pkg::CMD_POP_FRONT, 32'sd0, 32'sd0);
    send_command(skvd_pkg::CMD_PUSH_BACK, 32'sh55555555, 32'shAAAAAAAA);
    send_command(skvd_pkg::CMD_PUSH_FRONT, 32'shAAAAAAAA, 32'sh55555555);
    send_command(skvd_pkg::CMD_CLEAR, 32'sd0, 32'sd0);
    send_command(skvd_pkg::CMD_POP_BACK, 32'sd0, 32'sd0);
    drain_results();

    burst_left = 0;
    mode = MODE_MIXED;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 21; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          case ($urandom_range(2))
            0: mode = MODE_FILL;
            1: mode = MODE_DRAIN;
            default: mode = MODE_MIXED;
          endcase
          burst_left = $urandom_range(30, 8);
        end
        burst_left--;
        send_command(pick_command(mode), random_word(), random_word());
        if (n == PHASE_ITEMS / 2) drain_results();
      end
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    $display("covered %0d commands over three idle phases", commands);
    $display("%0d adds dropped on a full store, %0d pops on an empty store",
             full_drops, empty_pops);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("sorted_key_value_deque verification clean");
    end else begin
      $display("sorted_key_value_deque verification failed");
    end
    $finish;
  end

endmodule
